// File: sv/skse_pkg.sv
// ----------------------------------------------------------------------------
// skse_pkg
// Shared types and constants for the sorted key set engine.
// ----------------------------------------------------------------------------
package skse_pkg;

  localparam int KEY_W   = 16;
  localparam int OP_W    = 2;
  localparam int KCOUNT_W = 9;

  typedef enum logic [OP_W-1:0] {
    OP_MEMBER = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_CMP,
    ST_DECIDE,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_PLACE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic                success;
    logic                full_error;
    logic [KCOUNT_W-1:0] key_count;
  } res_t;

endpackage

// File: sv/skse_mem.sv
// ----------------------------------------------------------------------------
// skse_mem
// Key store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module skse_mem
  import skse_pkg::*;
#(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [KEY_W-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [KEY_W-1:0] rdata
);

  logic [KEY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/skse_ctrl.sv
// ----------------------------------------------------------------------------
// skse_ctrl
// Sequencer: binary search over the store, then shifts entries one at a time
// to open or close a slot.
// ----------------------------------------------------------------------------
module skse_ctrl
  import skse_pkg::*;
#(
  parameter int CAPACITY = 256,
  parameter int AW       = 8,
  parameter int CW       = 9
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [OP_W-1:0]  in_op,
  input  logic [KEY_W-1:0] in_key,
  output logic             res_valid,
  input  logic             res_ready,
  output res_t             res,
  output logic             mem_we,
  output logic [AW-1:0]    mem_waddr,
  output logic [KEY_W-1:0] mem_wdata,
  output logic             mem_re,
  output logic [AW-1:0]    mem_raddr,
  input  logic [KEY_W-1:0] mem_rdata
);

  localparam int XW = (CW > KCOUNT_W) ? CW : KCOUNT_W;

  state_t           state_r, state_nxt;
  logic [OP_W-1:0]  op_r, op_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [CW-1:0]    lo_r, lo_nxt;
  logic [CW-1:0]    hi_r, hi_nxt;
  logic [CW-1:0]    mid_r, mid_nxt;
  logic [CW-1:0]    ptr_r, ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             found_r, found_nxt;
  logic             succ_r, succ_nxt;
  logic             full_r, full_nxt;

  logic [CW:0]      mid_sum;
  logic [CW-1:0]    mid_w;
  logic [CW-1:0]    ptr_inc;
  logic [CW-1:0]    cnt_dec;
  logic             is_ins;
  logic             cap_hit;
  logic [XW-1:0]    cnt_ext;

  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid_w   = mid_sum[CW:1];
  assign ptr_inc = ptr_r + CW'(1);
  assign cnt_dec = count_r - CW'(1);
  assign is_ins  = (op_t'(op_r) == OP_INSERT);
  assign cap_hit = (count_r == CW'(CAPACITY));
  assign cnt_ext = XW'(count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    key_r   <= key_nxt;
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    mid_r   <= mid_nxt;
    ptr_r   <= ptr_nxt;
    found_r <= found_nxt;
    succ_r  <= succ_nxt;
    full_r  <= full_nxt;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_SEARCH;
      end
      ST_SEARCH: begin
        state_nxt = (lo_r < hi_r) ? ST_CMP : ST_DECIDE;
      end
      ST_CMP: begin
        state_nxt = ST_SEARCH;
      end
      ST_DECIDE: begin
        state_nxt = ST_FINISH;
        case (op_t'(op_r))
          OP_INSERT: begin
            if (!found_r && !cap_hit) begin
              state_nxt = (lo_r == count_r) ? ST_PLACE : ST_SHIFT_RD;
            end
          end
          OP_DELETE: begin
            if (found_r && (lo_r != cnt_dec)) state_nxt = ST_SHIFT_RD;
          end
          default: state_nxt = ST_FINISH;
        endcase
      end
      ST_SHIFT_RD: begin
        state_nxt = ST_SHIFT_WR;
      end
      ST_SHIFT_WR: begin
        if (is_ins) begin
          state_nxt = (ptr_r == lo_r) ? ST_PLACE : ST_SHIFT_RD;
        end else begin
          state_nxt = (ptr_inc == cnt_dec) ? ST_FINISH : ST_SHIFT_RD;
        end
      end
      ST_PLACE: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (res_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs and memory port drive
  always_comb begin
    in_ready  = 1'b0;
    res_valid = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = ptr_r[AW-1:0];
    mem_wdata = mem_rdata;
    mem_re    = 1'b0;
    mem_raddr = mid_w[AW-1:0];
    unique case (state_r)
      ST_IDLE:   in_ready = 1'b1;
      ST_SEARCH: mem_re = (lo_r < hi_r);
      ST_SHIFT_RD: begin
        mem_re    = 1'b1;
        mem_raddr = is_ins ? ptr_r[AW-1:0] : ptr_inc[AW-1:0];
      end
      ST_SHIFT_WR: begin
        mem_we    = 1'b1;
        mem_waddr = is_ins ? ptr_inc[AW-1:0] : ptr_r[AW-1:0];
      end
      ST_PLACE: begin
        mem_we    = 1'b1;
        mem_waddr = lo_r[AW-1:0];
        mem_wdata = key_r;
      end
      ST_FINISH: res_valid = 1'b1;
      default: ;
    endcase
  end

  assign res.success    = succ_r;
  assign res.full_error = full_r;
  assign res.key_count  = cnt_ext[KCOUNT_W-1:0];

  // datapath
  always_comb begin
    op_nxt    = op_r;
    key_nxt   = key_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    mid_nxt   = mid_r;
    ptr_nxt   = ptr_r;
    count_nxt = count_r;
    found_nxt = found_r;
    succ_nxt  = succ_r;
    full_nxt  = full_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_op;
          key_nxt   = in_key;
          lo_nxt    = '0;
          hi_nxt    = count_r;
          found_nxt = 1'b0;
          succ_nxt  = 1'b0;
          full_nxt  = 1'b0;
        end
      end
      ST_SEARCH: mid_nxt = mid_w;
      ST_CMP: begin
        // lower bound: keys are distinct, so a held key is always probed
        if (mem_rdata < key_r) lo_nxt = mid_r + CW'(1);
        else                   hi_nxt = mid_r;
        if (mem_rdata == key_r) found_nxt = 1'b1;
      end
      ST_DECIDE: begin
        case (op_t'(op_r))
          OP_MEMBER: succ_nxt = found_r;
          OP_INSERT: begin
            if (!found_r) begin
              if (cap_hit) full_nxt = 1'b1;
              else         ptr_nxt  = cnt_dec;
            end
          end
          OP_DELETE: begin
            if (found_r) begin
              ptr_nxt = lo_r;
              if (lo_r == cnt_dec) begin
                count_nxt = cnt_dec;
                succ_nxt  = 1'b1;
              end
            end
          end
          default: ;
        endcase
      end
      ST_SHIFT_WR: begin
        if (is_ins) begin
          if (ptr_r != lo_r) ptr_nxt = ptr_r - CW'(1);
        end else if (ptr_inc == cnt_dec) begin
          count_nxt = cnt_dec;
          succ_nxt  = 1'b1;
        end else begin
          ptr_nxt = ptr_inc;
        end
      end
      ST_PLACE: begin
        count_nxt = count_r + CW'(1);
        succ_nxt  = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

// File: sv/sorted_key_set_engine_top.sv
// ----------------------------------------------------------------------------
// sorted_key_set_engine_top
// Ascending set of distinct 16-bit keys with member, insert and delete.
// ----------------------------------------------------------------------------
//   channel | ports                                  | direction
//   --------+----------------------------------------+----------
//   in      | in_valid in_ready in_op in_key         | to block
//   out     | out_valid out_ready out_success        | from block
//           | out_full_error out_key_count           |
//
// One item at a time. Search: each probe of the store is a read then a compare,
// about log2(count)+1 probes. Insert/delete then move each entry above the slot
// with one memory read and one write per entry; an insert then places the
// key in the opened slot.
// Reset clears the key count, sequencer state and output valid; the store needs no clearing.
// A result waits in the output register; the next transfer in is taken
// meanwhile, and the sequencer stalls at the end until the register frees.
// ----------------------------------------------------------------------------
module sorted_key_set_engine_top
  import skse_pkg::*;
#(
  parameter int CAPACITY = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [OP_W-1:0]     in_op,
  input  logic [KEY_W-1:0]    in_key,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_success,
  output logic                out_full_error,
  output logic [KCOUNT_W-1:0] out_key_count
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic             res_valid;
  logic             res_ready;
  res_t             res;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [KEY_W-1:0] mem_wdata;
  logic             mem_re;
  logic [AW-1:0]    mem_raddr;
  logic [KEY_W-1:0] mem_rdata;

  logic             out_valid_r, out_valid_nxt;
  res_t             out_res_r;

  skse_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_op     (in_op),
    .in_key    (in_key),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  skse_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) out_valid_nxt = 1'b1;
    else if (out_ready)         out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_success    = out_res_r.success;
  assign out_full_error = out_res_r.full_error;
  assign out_key_count  = out_res_r.key_count;

endmodule

// File: sv/skse_checker.sv
// ----------------------------------------------------------------------------
// skse_checker
// Port-level checks on the sorted key set engine, bound to the top level.
// ----------------------------------------------------------------------------
module skse_checker
  import skse_pkg::*;
#(
  parameter int CAPACITY = 256
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic                out_success,
  input logic                out_full_error,
  input logic [KCOUNT_W-1:0] out_key_count
);

  // a held result stays put until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_success)
      && $stable(out_full_error) && $stable(out_key_count))
    else $error("result changed while stalled");

  // one item in flight: no transfer in right after another
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  a_full_not_success: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_success && out_full_error))
    else $error("success and full_error together");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_full_error |-> out_key_count == KCOUNT_W'(CAPACITY))
    else $error("full_error with set not full");

endmodule

bind sorted_key_set_engine_top skse_checker #(
  .CAPACITY (CAPACITY)
) u_skse_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_success    (out_success),
  .out_full_error (out_full_error),
  .out_key_count  (out_key_count)
);
